### rtl/pif_pkg.sv
// ----------------------------------------------------------------------------
// pif_pkg: shared types and constants of the integer formatter
// Holds the command passed from the front end to the back end, the back end
// states and the digit character function.
// ----------------------------------------------------------------------------
`default_nettype none

package pif_pkg;

  localparam int unsigned WidthLimit = 30;
  localparam int unsigned IntBits    = 16;
  localparam int unsigned LongBits   = 32;
  localparam int unsigned MaxResults = 33;
  localparam int unsigned MaxDigits  = 32;
  localparam int unsigned CmdDepth   = 2;

  // kind of work handed to the back end
  typedef enum logic [1:0] {
    CMD_CHAR = 2'd0,
    CMD_CONV = 2'd1
  } cmd_kind_e;

  typedef enum logic [1:0] {
    RADIX_2  = 2'd0,
    RADIX_8  = 2'd1,
    RADIX_10 = 2'd2,
    RADIX_16 = 2'd3
  } radix_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [7:0]  ch;
    logic [31:0] arg;
    radix_e      radix;
    logic        upper;
    logic        is_signed;
    logic        long_flag;
    logic        zero_fill;
    logic        left_justify;
    logic [4:0]  field_width;
  } cmd_t;

  // back end sequencer states
  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_DIV   = 3'd1,
    ST_ZPAD  = 3'd2,
    ST_LPAD  = 3'd3,
    ST_DIGIT = 3'd4,
    ST_RPAD  = 3'd5,
    ST_CHAR  = 3'd6
  } be_state_e;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] c;
    if (d < 4'd10) c = 8'h30 + {4'd0, d};
    else if (upper) c = 8'h37 + {4'd0, d};
    else c = 8'h57 + {4'd0, d};
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/pif_ram.sv
// ----------------------------------------------------------------------------
// pif_ram: generic single port write, single port read RAM
// Read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module pif_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### rtl/pif_front.sv
// ----------------------------------------------------------------------------
// pif_front: format character parser
// Tracks the spec state and turns echoes and conversions into commands.
// ----------------------------------------------------------------------------
`default_nettype none

module pif_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  output logic               full_o,
  input  wire logic [7:0]    fmt_char_i,
  input  wire logic [31:0]   argument_i,
  output logic               cmd_valid_o,
  output pif_pkg::cmd_t      cmd_o,
  input  wire logic          cmd_full_i
);
  import pif_pkg::*;

  logic       in_spec_q, in_spec_d;
  logic       long_q, long_d;
  logic [4:0] width_q, width_d;
  logic       zero_q, zero_d;
  logic       left_q, left_d;
  logic       acc;
  logic [8:0] wnext;

  assign full_o = cmd_full_i;
  assign acc    = push_i && !cmd_full_i;
  assign wnext  = {1'b0, width_q, 3'd0} + {3'd0, width_q, 1'b0}
                  + {5'd0, fmt_char_i[3:0]};

  // classify the character
  always_comb begin
    in_spec_d = in_spec_q;
    long_d    = long_q;
    width_d   = width_q;
    zero_d    = zero_q;
    left_d    = left_q;
    cmd_valid_o        = 1'b0;
    cmd_o              = '0;
    cmd_o.kind         = CMD_CHAR;
    cmd_o.ch           = fmt_char_i;
    cmd_o.arg          = argument_i;
    cmd_o.radix        = RADIX_10;
    cmd_o.long_flag    = long_q;
    cmd_o.zero_fill    = zero_q;
    cmd_o.left_justify = left_q;
    cmd_o.field_width  = width_q;
    if (acc) begin
      if (fmt_char_i == 8'h00) begin
        in_spec_d = 1'b0; long_d = 1'b0; width_d = '0; zero_d = 1'b0; left_d = 1'b0;
      end else if (!in_spec_q) begin
        if (fmt_char_i == "%") begin
          in_spec_d = 1'b1; long_d = 1'b0; width_d = '0; zero_d = 1'b0; left_d = 1'b0;
        end else begin
          cmd_valid_o = 1'b1;
        end
      end else if (fmt_char_i == "l") begin
        long_d = 1'b1;
      end else if (fmt_char_i inside {["0":"9"]}) begin
        if (width_q == '0 && fmt_char_i == "0") zero_d = 1'b1;
        else if (wnext > 9'(WidthLimit)) width_d = 5'(WidthLimit);
        else width_d = wnext[4:0];
      end else if (fmt_char_i == "-") begin
        left_d = 1'b1;
      end else begin
        cmd_valid_o = 1'b1;
        cmd_o.kind  = CMD_CONV;
        case (fmt_char_i)
          "d": begin cmd_o.is_signed = 1'b1; end
          "u": ;
          "x": cmd_o.radix = RADIX_16;
          "X": begin cmd_o.radix = RADIX_16; cmd_o.upper = 1'b1; end
          "o": cmd_o.radix = RADIX_8;
          "b": cmd_o.radix = RADIX_2;
          "p": begin
            cmd_o.radix = RADIX_16; cmd_o.upper = 1'b1;
            cmd_o.long_flag = 1'b1; cmd_o.zero_fill = 1'b1;
            cmd_o.field_width = 5'd8;
          end
          "c": begin cmd_o.kind = CMD_CHAR; cmd_o.ch = argument_i[7:0]; end
          default: cmd_o.kind = CMD_CHAR;
        endcase
        in_spec_d = 1'b0; long_d = 1'b0; width_d = '0; zero_d = 1'b0; left_d = 1'b0;
      end
    end
  end

  // spec state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_spec_q <= 1'b0; long_q <= 1'b0; width_q <= '0; zero_q <= 1'b0; left_q <= 1'b0;
    end else begin
      in_spec_q <= in_spec_d; long_q <= long_d; width_q <= width_d;
      zero_q <= zero_d; left_q <= left_d;
    end
  end

endmodule

`default_nettype wire

### rtl/pif_cmd_fifo.sv
// ----------------------------------------------------------------------------
// pif_cmd_fifo: short command queue between front and back end
// Two entries in flip-flops.
// ----------------------------------------------------------------------------
`default_nettype none

module pif_cmd_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          wr_i,
  input  wire pif_pkg::cmd_t wdata_i,
  output logic               full_o,
  output logic               valid_o,
  output pif_pkg::cmd_t      rdata_o,
  input  wire logic          rd_i
);
  import pif_pkg::*;

  cmd_t                          mem_q [CmdDepth];
  logic [$clog2(CmdDepth)-1:0]   wp_q, rp_q;
  logic [$clog2(CmdDepth):0]     cnt_q;
  logic                          do_wr, do_rd;

  assign full_o  = cnt_q == ($clog2(CmdDepth)+1)'(CmdDepth);
  assign valid_o = cnt_q != '0;
  assign rdata_o = mem_q[rp_q];
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && valid_o;

  // storage
  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wp_q] <= wdata_i;
  end

  // pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (do_wr) wp_q <= wp_q + 1'b1;
      if (do_rd) rp_q <= rp_q + 1'b1;
      if (do_wr && !do_rd) cnt_q <= cnt_q + 1'b1;
      else if (do_rd && !do_wr) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

`default_nettype wire

### rtl/pif_back.sv
// ----------------------------------------------------------------------------
// pif_back: conversion sequencer
// Produces digits one per cycle into the digit RAM, then emits padding,
// sign and digits through a one-entry output register; echoes characters too.
// ----------------------------------------------------------------------------
`default_nettype none

module pif_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cmd_valid_i,
  input  wire pif_pkg::cmd_t cmd_i,
  output logic               cmd_rd_o,
  output logic               empty_o,
  input  wire logic          pop_i,
  output logic [7:0]         out_char_o,
  output logic               last_of_run_o
);
  import pif_pkg::*;

  be_state_e   state_q, state_d;
  cmd_t        cmd_q;
  logic [31:0] val_q, val_d;
  logic        neg_q, neg_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [5:0]  pad_q, pad_d;
  logic [5:0]  ridx_q, ridx_d;
  logic [5:0]  emitted_q, emitted_d;
  logic        pend_q, pend_d;
  logic        ovalid_q, ovalid_d;
  logic [7:0]  ochar_q, ochar_d;
  logic        olast_q, olast_d;

  logic        we;
  logic [4:0]  waddr;
  logic [7:0]  wdata;
  logic [4:0]  raddr;
  logic [7:0]  rdata;

  logic        space;
  logic [31:0] quo;
  logic [3:0]  rem;
  logic [31:0] mask;
  logic [31:0] masked;
  logic        sign_bit;
  logic [5:0]  tgt;
  logic        push_o;
  logic [7:0]  push_c;
  logic        push_l;

  pif_ram #(.Width(8), .Depth(MaxDigits)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign empty_o       = !ovalid_q;
  assign out_char_o    = ochar_q;
  assign last_of_run_o = olast_q;
  assign space         = !ovalid_q || pop_i;

  // argument masking for the start of a conversion
  assign mask     = cmd_i.long_flag ? 32'hFFFF_FFFF : {{(32-IntBits){1'b0}}, {IntBits{1'b1}}};
  assign masked   = cmd_i.arg & mask;
  assign sign_bit = cmd_i.long_flag ? cmd_i.arg[LongBits-1] : cmd_i.arg[IntBits-1];

  // one digit step: divide by radix
  always_comb begin
    quo = '0;
    rem = '0;
    case (cmd_q.radix)
      RADIX_2:  begin quo = val_q >> 1; rem = {3'd0, val_q[0]}; end
      RADIX_8:  begin quo = val_q >> 3; rem = {1'b0, val_q[2:0]}; end
      RADIX_16: begin quo = val_q >> 4; rem = val_q[3:0]; end
      RADIX_10: begin
        quo = 32'((64'(val_q) * 64'hCCCC_CCCD) >> 35);
        rem = 4'(val_q - 32'((quo << 3) + (quo << 1)));
      end
      default: ;
    endcase
  end

  assign tgt = (6'(cmd_q.field_width) > 6'(neg_q)) ?
               6'(cmd_q.field_width) - 6'(neg_q) : 6'd0;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (cmd_valid_i)
        state_d = (cmd_i.kind == CMD_CONV) ? ST_DIV : ST_CHAR;
      ST_CHAR: if (space) state_d = ST_IDLE;
      ST_DIV: if (quo == '0 || cnt_q == 6'(MaxDigits - 1))
        state_d = cmd_q.zero_fill ? ST_ZPAD : ST_LPAD;
      ST_ZPAD: if (cnt_q >= tgt || cnt_q == 6'(MaxDigits)) state_d = ST_LPAD;
      ST_LPAD: if (pad_q == '0 || cmd_q.zero_fill || cmd_q.left_justify)
        state_d = ST_DIGIT;
      ST_DIGIT: if (space && ridx_q == '0 && !pend_q)
        state_d = (pad_q != '0 && cmd_q.left_justify && !cmd_q.zero_fill)
                  ? ST_RPAD : ST_IDLE;
      ST_RPAD: if (space && pad_q == 6'd1) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    val_d = val_q; neg_d = neg_q; cnt_d = cnt_q; pad_d = pad_q; ridx_d = ridx_q;
    emitted_d = emitted_q; pend_d = pend_q;
    we = 1'b0; waddr = cnt_q[4:0]; wdata = 8'h30; raddr = ridx_q[4:0];
    cmd_rd_o = 1'b0;
    push_o = 1'b0; push_c = 8'h20; push_l = 1'b0;
    case (state_q)
      ST_IDLE: if (cmd_valid_i) begin
        cmd_rd_o = 1'b1;
        emitted_d = '0;
        cnt_d = '0;
        if (cmd_i.is_signed && sign_bit) begin
          neg_d = 1'b1; val_d = (32'd0 - masked) & mask;
        end else begin
          neg_d = 1'b0; val_d = masked;
        end
      end
      ST_CHAR: if (space) begin
        push_o = 1'b1; push_c = cmd_q.ch; push_l = 1'b1;
      end
      ST_DIV: begin
        we = 1'b1; wdata = digit_char(rem, cmd_q.upper);
        val_d = quo; cnt_d = cnt_q + 1'b1;
        // space padding from the final digit count and sign
        if (quo == '0 || cnt_q == 6'(MaxDigits - 1)) begin
          pad_d = (6'(cmd_q.field_width) > cnt_q + 6'd1 + 6'(neg_q)) ?
                  6'(cmd_q.field_width) - cnt_q - 6'd1 - 6'(neg_q) : 6'd0;
        end
      end
      ST_ZPAD: if (!(cnt_q >= tgt || cnt_q == 6'(MaxDigits))) begin
        we = 1'b1; cnt_d = cnt_q + 1'b1;
      end else begin
        // sign sits above the digits, emitted first
        pad_d = '0;
        ridx_d = cnt_q - 1'b1;
        pend_d = 1'b1;
      end
      ST_LPAD: begin
        if (pad_q == '0 || cmd_q.zero_fill || cmd_q.left_justify) begin
          ridx_d = cnt_q - 1'b1; pend_d = 1'b1;
        end else if (space) begin
          push_o = 1'b1; pad_d = pad_q - 1'b1;
        end
      end
      ST_DIGIT: if (space) begin
        // pend: read issued, sign first if negative
        if (neg_q) begin
          push_o = 1'b1; push_c = 8'h2D; neg_d = 1'b0;
        end else if (pend_q) begin
          pend_d = 1'b0;
        end else begin
          push_o = 1'b1; push_c = rdata;
          push_l = (ridx_q == '0) && !(pad_q != '0 && cmd_q.left_justify);
          if (ridx_q != '0) begin ridx_d = ridx_q - 1'b1; pend_d = 1'b1; end
          raddr = ridx_d[4:0];
        end
      end
      ST_RPAD: if (space) begin
        push_o = 1'b1; pad_d = pad_q - 1'b1; push_l = pad_q == 6'd1;
      end
      default: ;
    endcase
    if (push_o) emitted_d = emitted_q + 1'b1;
  end

  // output register
  always_comb begin
    ovalid_d = ovalid_q && !pop_i;
    ochar_d  = ochar_q;
    olast_d  = olast_q;
    if (push_o) begin
      ovalid_d = emitted_q < 6'(MaxResults);
      ochar_d  = push_c;
      olast_d  = push_l || (emitted_q == 6'(MaxResults - 1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d; ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_rd_o) cmd_q <= cmd_i;
    val_q <= val_d; neg_q <= neg_d; cnt_q <= cnt_d; pad_q <= pad_d;
    ridx_q <= ridx_d; emitted_q <= emitted_d; pend_q <= pend_d;
    ochar_q <= ochar_d; olast_q <= olast_d;
  end

endmodule

`default_nettype wire

### rtl/printf_integer_formatter_unit.sv
// ----------------------------------------------------------------------------
// printf_integer_formatter_unit: integer printf formatter
// Parses format characters and emits the formatted characters.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive fmt_char_i and argument_i, raise push when full is
//   low. Flag, width and '%' characters are absorbed by the parser;
//   echoed characters and conversions go through a two-entry command
//   queue to the back end.
//   Output queue: while empty is low out_char_o/last_of_run_o show the
//   oldest character; pop takes it. last_of_run_o marks an item's final
//   character.
//   A plain character passes the command queue and the back end on its
//   way to the output register. A conversion runs the divide loop once
//   per digit (up to 32 digits), writes any zero pads, then emits each
//   character with a RAM read per digit.
//   Throughput is set by the single back end sequencer.
//   Reset clears parser state, queue and output register. When the
//   receiver stalls, the back end holds, the command queue fills and full
//   rises.
// ----------------------------------------------------------------------------
`default_nettype none

module printf_integer_formatter_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  fmt_char_i,
  input  wire logic [31:0] argument_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       out_char_o,
  output logic             last_of_run_o
);
  import pif_pkg::*;

  logic  fe_valid, q_full, q_valid, q_rd;
  cmd_t  fe_cmd, q_cmd;

  pif_front u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full),
    .fmt_char_i, .argument_i,
    .cmd_valid_o(fe_valid), .cmd_o(fe_cmd), .cmd_full_i(q_full)
  );

  pif_cmd_fifo u_fifo (
    .clk_i, .rst_ni, .wr_i(fe_valid), .wdata_i(fe_cmd), .full_o(q_full),
    .valid_o(q_valid), .rdata_o(q_cmd), .rd_i(q_rd)
  );

  pif_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(q_valid), .cmd_i(q_cmd), .cmd_rd_o(q_rd),
    .empty_o(empty), .pop_i(pop), .out_char_o, .last_of_run_o
  );

endmodule

`default_nettype wire

### rtl/pif_checker.sv
// ----------------------------------------------------------------------------
// pif_checker: port level checks of the formatter
// Watches the output queue behaviour.
// ----------------------------------------------------------------------------
`default_nettype none

module pif_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic [7:0] out_char_o,
  input wire logic       last_of_run_o
);

  // a waiting result holds until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_char_o) && $stable(last_of_run_o)))
    else $error("result changed while stalled");

  // output queue starts empty after reset
  a_rst: assert property (@(posedge clk_i) $rose(rst_ni) |-> empty)
    else $error("result present after reset");

  // a NUL is only emitted as the last character of a run
  a_nul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> out_char_o != 8'h00 || last_of_run_o)
    else $error("NUL emitted mid run");

endmodule

bind printf_integer_formatter_unit pif_checker u_pif_checker (
  .clk_i, .rst_ni, .empty, .pop, .out_char_o, .last_of_run_o
);

`default_nettype wire

### tb/sv/tb_printf_integer_formatter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_printf_integer_formatter_unit: regression for the integer formatter
// Feeds format strings character by character through the input queue and
// checks every emitted character against a behavioural predictor of the
// parser and conversion logic, with random gaps on both queues.
// ----------------------------------------------------------------------------

module tb_printf_integer_formatter_unit;

  localparam int unsigned CycleLimit = 400000;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } out_txn_t;

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic [7:0]  fmt_char_i;
  logic [31:0] argument_i;
  logic        empty;
  logic        pop;
  logic [7:0]  out_char_o;
  logic        last_of_run_o;

  // predictor state
  logic       fmt_in_spec;
  logic       fmt_long;
  logic [4:0] fmt_width;
  logic       fmt_zero;
  logic       fmt_left;

  out_txn_t   char_queue[$];
  int unsigned error_count;
  int unsigned cycle_count;
  bit          sink_stall_en;

  printf_integer_formatter_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .fmt_char_i    (fmt_char_i),
    .argument_i    (argument_i),
    .empty         (empty),
    .pop           (pop),
    .out_char_o    (out_char_o),
    .last_of_run_o (last_of_run_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // cycle limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("printf_integer_formatter_unit regression: fail");
      $finish;
    end
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // clear the open spec
  function automatic void spec_clear();
    fmt_in_spec = 1'b0;
    fmt_long    = 1'b0;
    fmt_width   = 5'd0;
    fmt_zero    = 1'b0;
    fmt_left    = 1'b0;
  endfunction

  // expected characters for one numeric conversion
  function automatic void predict_number(ref logic [7:0] seq[$], input int unsigned radix,
                                         input bit upper, input bit is_signed,
                                         input logic [31:0] arg);
    logic [31:0] mask;
    logic [31:0] mag;
    logic [7:0]  digits[$];
    bit          neg;
    int unsigned target;
    int unsigned pad;
    int unsigned d;
    int          i;
    mask = fmt_long ? 32'hFFFF_FFFF : 32'h0000_FFFF;
    mag  = arg & mask;
    neg  = 1'b0;
    if (is_signed && (fmt_long ? mag[31] : mag[15])) begin
      neg = 1'b1;
      mag = (32'd0 - mag) & mask;
    end
    do begin
      d = mag % radix;
      if (d < 10) digits.push_back(8'h30 + d[7:0]);
      else digits.push_back((upper ? 8'h37 : 8'h57) + d[7:0]);
      mag = mag / radix;
    end while (mag != 0 && digits.size() < 32);
    if (fmt_zero) begin
      target = (fmt_width > neg) ? fmt_width - neg : 0;
      while (digits.size() < target && digits.size() < 32) digits.push_back("0");
      if (neg) digits.push_back("-");
      for (i = digits.size() - 1; i >= 0; i--) seq.push_back(digits[i]);
    end else begin
      if (neg) digits.push_back("-");
      pad = (fmt_width > digits.size()) ? fmt_width - digits.size() : 0;
      if (!fmt_left) repeat (pad) seq.push_back(" ");
      for (i = digits.size() - 1; i >= 0; i--) seq.push_back(digits[i]);
      if (fmt_left) repeat (pad) seq.push_back(" ");
    end
  endfunction

  // advance the parser by one character and queue what it should emit
  function automatic void predict_format_char(input logic [7:0] c, input logic [31:0] arg);
    logic [7:0]  seq[$];
    int unsigned w;
    if (c == 8'h00) begin
      spec_clear();
      return;
    end
    if (!fmt_in_spec) begin
      if (c == "%") begin
        spec_clear();
        fmt_in_spec = 1'b1;
      end else begin
        seq.push_back(c);
      end
    end else if (c == "l") begin
      fmt_long = 1'b1;
    end else if (c >= "0" && c <= "9") begin
      if (fmt_width == 0 && c == "0") begin
        fmt_zero = 1'b1;
      end else begin
        w = fmt_width * 10 + (c - "0");
        fmt_width = (w > 30) ? 5'd30 : w[4:0];
      end
    end else if (c == "-") begin
      fmt_left = 1'b1;
    end else begin
      case (c)
        "d": predict_number(seq, 10, 1'b0, 1'b1, arg);
        "u": predict_number(seq, 10, 1'b0, 1'b0, arg);
        "x": predict_number(seq, 16, 1'b0, 1'b0, arg);
        "X": predict_number(seq, 16, 1'b1, 1'b0, arg);
        "o": predict_number(seq, 8, 1'b0, 1'b0, arg);
        "b": predict_number(seq, 2, 1'b0, 1'b0, arg);
        "p": begin
          fmt_width = 5'd8;
          fmt_zero  = 1'b1;
          fmt_long  = 1'b1;
          predict_number(seq, 16, 1'b1, 1'b0, arg);
        end
        "c": seq.push_back(arg[7:0]);
        default: seq.push_back(c);
      endcase
      spec_clear();
    end
    while (seq.size() > 33) void'(seq.pop_back());
    foreach (seq[i]) char_queue.push_back('{ch: seq[i], last: (i == seq.size() - 1)});
  endfunction

  // send one character with its argument
  task automatic send_char(input logic [7:0] c, input logic [31:0] arg);
    int unsigned g;
    g = gap_len();
    repeat (g) @(negedge clk_i);
    fmt_char_i = c;
    argument_i = arg;
    push = 1'b1;
    do @(posedge clk_i); while (full);
    predict_format_char(c, arg);
    @(negedge clk_i);
    push = 1'b0;
  endtask

  task automatic send_text(input string s, input logic [31:0] arg);
    foreach (s[i]) send_char(s[i], arg);
  endtask

  task automatic wait_drained();
    while (char_queue.size() != 0) @(negedge clk_i);
    repeat (120) @(negedge clk_i);
  endtask

  // output side: random pop and compare
  always @(negedge clk_i) begin
    if (rst_ni) pop <= sink_stall_en ? ($urandom_range(0, 3) != 0) : 1'b1;
  end

  always @(posedge clk_i) begin
    out_txn_t exp_txn;
    if (rst_ni && pop && !empty) begin
      if (char_queue.size() == 0) begin
        error_count++;
        $display("%0t: unexpected char expected none actual %h last %b",
                 $time, out_char_o, last_of_run_o);
      end else begin
        exp_txn = char_queue.pop_front();
        if (out_char_o !== exp_txn.ch || last_of_run_o !== exp_txn.last) begin
          error_count++;
          $display("%0t: mismatch expected %h/%b actual %h/%b", $time,
                   exp_txn.ch, exp_txn.last, out_char_o, last_of_run_o);
        end
      end
    end
  end

  // plain echo, NUL and unknown characters
  task automatic test_echo();
    send_text("Hi!", 32'd0);
    send_char(8'hFF, 32'd0);
    send_char(8'h01, 32'd0);
    send_text("%%", 32'd0);
    send_text("%5s", 32'd0);
    send_text("%-l", 32'd0);
    send_char(8'h00, 32'd0);
    send_char(8'h80, 32'd0);
  endtask

  // every conversion with extremes
  task automatic test_conversions();
    send_text("%d", 32'h0000_8000);
    send_text("%ld", 32'h8000_0000);
    send_text("%05d", 32'h0000_FFFF);
    send_text("%-6u", 32'd0);
    send_text("%lx", 32'hFFFF_FFFF);
    send_text("%X", 32'h0000_ABCD);
    send_text("%lo", 32'hFFFF_FFFF);
    send_text("%lb", 32'hFFFF_FFFF);
    send_text("%099b", 32'd5);
    send_text("%p", 32'h0000_12AB);
    send_text("%c", 32'hFFFF_FF41);
  endtask

  // random format strings, mostly well formed
  task automatic test_random();
    logic [7:0] convs[8];
    logic [7:0] flags[5];
    int unsigned n;
    convs = '{"d", "u", "x", "X", "o", "b", "p", "c"};
    flags = '{"-", "0", "l", "1", "9"};
    n = 0;
    while (n < 160) begin
      if ($urandom_range(0, 9) < 7) begin
        send_char("%", $urandom);
        n++;
        repeat ($urandom_range(0, 3)) begin
          send_char(flags[$urandom_range(0, 4)], $urandom);
          n++;
        end
        send_char(convs[$urandom_range(0, 7)], $urandom);
      end else begin
        send_char(8'($urandom_range(0, 255)), $urandom);
      end
      n++;
      if (n > 100 && n < 106) sink_stall_en = 1'b0;
      else sink_stall_en = 1'b1;
    end
  endtask

  // stimulus
  initial begin
    cycle_count   = 0;
    error_count   = 0;
    sink_stall_en = 1'b1;
    push       = 1'b0;
    pop        = 1'b0;
    fmt_char_i = 8'd0;
    argument_i = 32'd0;
    rst_ni     = 1'b0;
    spec_clear();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_echo();
    test_conversions();
    wait_drained();
    test_random();
    wait_drained();
    if (error_count == 0) begin
      $display("printf_integer_formatter_unit regression: pass");
    end else begin
      $display("printf_integer_formatter_unit regression: fail");
    end
    $finish;
  end

endmodule

### sim.f
rtl/pif_pkg.sv
rtl/pif_ram.sv
rtl/pif_front.sv
rtl/pif_cmd_fifo.sv
rtl/pif_back.sv
rtl/printf_integer_formatter_unit.sv
rtl/pif_checker.sv
tb/sv/tb_printf_integer_formatter_unit.sv
